>>> rtl/core/bdf_pkg.sv
`timescale 1ns / 1ps

package bdf_pkg;

	localparam int COORD_W  = 32;
	localparam int SLOT_W   = 6;
	localparam int UCOUNT_W = 7;

	typedef struct packed {
		logic [COORD_W-1:0] coord_x1;
		logic [COORD_W-1:0] coord_y1;
		logic [COORD_W-1:0] coord_x2;
		logic [COORD_W-1:0] coord_y2;
		logic               batch_end;
	} box_in_t;

	typedef struct packed {
		logic                is_new;
		logic [SLOT_W-1:0]   slot_index;
		logic [UCOUNT_W-1:0] unique_count;
		logic                table_full_drop;
		logic [COORD_W-1:0]  out_x1;
		logic [COORD_W-1:0]  out_y1;
		logic [COORD_W-1:0]  out_x2;
		logic [COORD_W-1:0]  out_y2;
		logic                batch_last;
	} result_t;

	// stored box, four raw single-precision patterns
	typedef struct packed {
		logic [COORD_W-1:0] x1;
		logic [COORD_W-1:0] y1;
		logic [COORD_W-1:0] x2;
		logic [COORD_W-1:0] y2;
	} box_t;

	// search token handed from cell to cell
	typedef struct packed {
		logic              active;
		logic              done;
		logic              is_new;
		logic [SLOT_W-1:0] slot;
	} token_t;

	localparam logic [COORD_W-1:0] MAG_MASK = 32'h7FFF_FFFF;
	localparam logic [COORD_W-1:0] INF_MAG  = 32'h7F80_0000;

	// ieee equality: nan matches nothing, signed zeros match
	function automatic logic coord_eq(input logic [COORD_W-1:0] a,
					  input logic [COORD_W-1:0] b);
		logic [COORD_W-1:0] ma;
		logic [COORD_W-1:0] mb;
		ma = a & MAG_MASK;
		mb = b & MAG_MASK;
		if (ma > INF_MAG || mb > INF_MAG) begin
			return 1'b0;
		end else if (ma == '0 && mb == '0) begin
			return 1'b1;
		end else begin
			return a == b;
		end
	endfunction

	function automatic logic box_eq(input box_t s, input box_t c);
		return coord_eq(s.x1, c.x1) && coord_eq(s.y1, c.y1) &&
		       coord_eq(s.x2, c.x2) && coord_eq(s.y2, c.y2);
	endfunction

endpackage

>>> rtl/core/box_duplicate_filter.sv
`timescale 1ns / 1ps
// port      dir  kind              word
// start     in   command strobe    box (box_in_t), taken when start and not busy
// busy      out  status            high from acceptance until the result strobe
// done      out  result strobe     result (result_t), valid for one cycle only
//
// the result strobe follows acceptance through the injection register, the register of
// every cell and the done register, and the next box can be taken at the edge that ends
// it: a search token walks the row of cells one cell per cycle, whatever the match.
// a new box may start in the cycle the result is shown.
// reset empties the table (count to zero); slot contents are not cleared.
// the receiver cannot stall; results are shown exactly once.

module box_duplicate_filter #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  bdf_pkg::box_in_t  box,
	output logic              busy,
	output logic              done,
	output bdf_pkg::result_t  result
);
	import bdf_pkg::*;

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	logic             busy_q;
	logic             inj_q;
	logic             done_q;
	logic [CNT_W-1:0] count_q;
	box_t             cand_q;
	logic             last_q;
	result_t          result_q;

	token_t           chain [TABLE_DEPTH+1];
	token_t           tail;
	logic             accept;
	logic             finish;
	logic             drop;
	logic [CNT_W:0]   count_next;

	assign accept = start && !busy_q;
	assign tail   = chain[TABLE_DEPTH];
	assign finish = tail.active;
	assign drop   = !tail.done;

	assign chain[0] = '{active: inj_q, done: 1'b0, is_new: 1'b0, slot: '0};

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		bdf_cell #(
			.CNT_W(CNT_W),
			.INDEX(i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cand   (cand_q),
			.count  (count_q),
			.tok_in (chain[i]),
			.tok_out(chain[i+1])
		);
	end

	assign count_next = {1'b0, count_q} + (CNT_W+1)'(tail.is_new && !drop);

	always_ff @(posedge clk) begin
		if (accept) begin
			cand_q <= '{x1: box.coord_x1, y1: box.coord_y1,
				    x2: box.coord_x2, y2: box.coord_y2};
			last_q <= box.batch_end;
		end
		if (finish) begin
			result_q.is_new          <= tail.is_new && !drop;
			result_q.slot_index      <= drop ? '0 : tail.slot;
			result_q.unique_count    <= UCOUNT_W'(count_next);
			result_q.table_full_drop <= drop;
			result_q.out_x1          <= cand_q.x1;
			result_q.out_y1          <= cand_q.y1;
			result_q.out_x2          <= cand_q.x2;
			result_q.out_y2          <= cand_q.y2;
			result_q.batch_last      <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			inj_q   <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			inj_q  <= accept;
			done_q <= finish;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (finish) begin
				busy_q <= 1'b0;
			end
			if (finish) begin
				// batch end clears the table after its result is formed
				count_q <= last_q ? '0 : count_next[CNT_W-1:0];
			end
		end
	end

	assign busy   = busy_q;
	assign done   = done_q;
	assign result = result_q;

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$past(done) && !busy)
		else $error("result strobe without a finished search");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && inj_q)
		else $error("accepted word did not start a search");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("unique count beyond table depth");

	a_new_xor_drop: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.is_new && result.table_full_drop))
		else $error("box both stored and dropped");

	a_drop_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		finish && drop |-> count_q == CNT_W'(TABLE_DEPTH))
		else $error("box dropped while table had room");

endmodule

>>> rtl/core/bdf_cell.sv
`timescale 1ns / 1ps

module bdf_cell #(
	parameter int CNT_W = 7,
	parameter int INDEX = 0
) (
	input  logic            clk,
	input  logic            arst_n,
	input  bdf_pkg::box_t   cand,
	input  logic [CNT_W-1:0] count,
	input  bdf_pkg::token_t tok_in,
	output bdf_pkg::token_t tok_out
);
	import bdf_pkg::*;

	localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);
	localparam logic [SLOT_W-1:0] IDX_SLOT = SLOT_W'(INDEX);

	box_t   entry_q;
	token_t tok_q;
	logic   live;
	logic   hit;
	logic   take;

	assign live = tok_in.active && !tok_in.done;
	// entries below the count hold boxes of this batch
	assign hit  = live && (IDX < count) && box_eq(entry_q, cand);
	// first free slot takes the box when nothing earlier matched
	assign take = live && (IDX == count);

	always_ff @(posedge clk) begin
		if (take) begin
			entry_q <= cand;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q.active <= tok_in.active;
			tok_q.done   <= tok_in.done | hit | take;
			tok_q.is_new <= take ? 1'b1 : tok_in.is_new;
			tok_q.slot   <= (hit || take) ? IDX_SLOT : tok_in.slot;
		end
	end

	assign tok_out = tok_q;

endmodule
